[rtl/obbo_pkg.sv]
// Shared types and sizes for the order book best bid / offer tracker.
// No dependencies; used by obbo_front, obbo_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package obbo_pkg;
	localparam int ORDER_SLOTS  = 4096;
	localparam int PRICE_LEVELS = 1024;  // power of two: level slot is price modulo this

	localparam int OID_W = $clog2(ORDER_SLOTS);
	localparam int LVL_W = $clog2(PRICE_LEVELS);
	localparam int CNT_W = OID_W + 1;
	localparam int TOT_W = 32 + OID_W + 1;
	localparam int SWP_N = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
	localparam int SWP_W = $clog2(SWP_N);

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_MODIFY = 3'd1;
	localparam logic [2:0] ACT_CANCEL = 3'd2;
	localparam logic [2:0] ACT_TRADE  = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [11:0] ord_id;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
	} item_t;

	typedef struct packed {
		logic        live;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} order_t;

	typedef struct packed {
		logic             occ;
		logic             side;
		logic [31:0]      price;
		logic [CNT_W-1:0] cnt;
		logic [TOT_W-1:0] tot;
	} level_t;
endpackage
`default_nettype wire

[rtl/obbo_front.sv]
// Front end: two-entry queue that takes input transfers and hands them to the back end.
// Depends on obbo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obbo_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire obbo_pkg::item_t in_item,
	output logic               q_valid,
	input  wire logic          q_pop,
	output obbo_pkg::item_t    q_item
);
	obbo_pkg::item_t slot_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

[rtl/obbo_back.sv]
// Back end: order and level memories, best-level tracking, rescan, clear sweep,
// BBO registers and the output register. Depends on obbo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obbo_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_pop,
	input  wire obbo_pkg::item_t q_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 is_trade,
	output logic                 echo_side,
	output logic [31:0]          echo_price,
	output logic                 bid_valid,
	output logic [31:0]          best_bid,
	output logic [31:0]          best_bid_qty,
	output logic                 ask_valid,
	output logic [31:0]          best_ask,
	output logic [31:0]          best_ask_qty
);
	localparam int OW = obbo_pkg::OID_W;
	localparam int LW = obbo_pkg::LVL_W;
	localparam int CW = obbo_pkg::CNT_W;
	localparam int TW = obbo_pkg::TOT_W;
	localparam int SW = obbo_pkg::SWP_W;

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD1   = 4'd2;
	localparam logic [3:0] S_EX1   = 4'd3;
	localparam logic [3:0] S_RD2   = 4'd4;
	localparam logic [3:0] S_EX2   = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_STAIL = 4'd7;
	localparam logic [3:0] S_REF   = 4'd8;
	localparam logic [3:0] S_REF2  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	obbo_pkg::order_t ord_mem [obbo_pkg::ORDER_SLOTS];
	obbo_pkg::level_t lvl_mem [obbo_pkg::PRICE_LEVELS];
	obbo_pkg::order_t ord_rd;
	obbo_pkg::level_t lvl_rd;

	logic [3:0] st_q;
	obbo_pkg::item_t cur_q;
	logic refresh_q, id_ok_q, emit_q;
	logic [SW-1:0] swp_q;
	logic [LW-1:0] li_q;
	logic lside_q;
	logic [31:0] oqty_q;
	logic [LW-1:0] scan_q, scan_idx_s1;
	logic scan_vld_s1, scan_side_q, scan_fnd_q;
	logic [LW-1:0] scan_bi_q;
	logic [31:0] scan_bp_q;

	logic [1:0] bk_v_q;
	logic [LW-1:0] bk_idx_q [2];
	logic [31:0] bk_p_q [2];
	logic [1:0] bbo_v_q;
	logic [31:0] bbo_p_q [2];
	logic [31:0] bbo_qty_q [2];

	logic [1:0] obbo_out_v_q;
	logic [31:0] obbo_out_p_q [2];
	logic [31:0] obbo_out_qty_q [2];

	logic ord_we, lvl_we;
	logic [OW-1:0] ord_wa, ord_ra;
	logic [LW-1:0] lvl_wa, lvl_ra;
	obbo_pkg::order_t ord_wd;
	obbo_pkg::level_t lvl_wd;

	logic [OW-1:0] cur_oid;
	logic [LW-1:0] cur_li;
	logic add_ok, add_new, add_better, cxl_free, cxl_rescan, ord_hit;
	logic scan_take, refresh_now, id_ok_now;
	logic sweep_ord, sweep_lvl;
	logic emit_now;
	logic [31:0] ref_qty;

	assign cur_oid   = OW'(cur_q.ord_id);
	assign cur_li    = LW'(cur_q.price);
	assign id_ok_now = 32'(q_item.ord_id) < 32'(obbo_pkg::ORDER_SLOTS);
	assign refresh_now = !bk_v_q[q_item.side] ||
		(q_item.side ? (q_item.price <= bk_p_q[1]) : (q_item.price >= bk_p_q[0]));
	assign sweep_ord = (SW + 1)'(swp_q) < (SW + 1)'(obbo_pkg::ORDER_SLOTS);
	assign sweep_lvl = (SW + 1)'(swp_q) < (SW + 1)'(obbo_pkg::PRICE_LEVELS);

	assign ord_hit = ord_rd.live;
	assign add_new = !lvl_rd.occ;
	assign add_ok  = !ord_rd.live &&
		(!lvl_rd.occ || (lvl_rd.side == cur_q.side && lvl_rd.price == cur_q.price));
	assign add_better = !bk_v_q[cur_q.side] ||
		(cur_q.side ? (cur_q.price < bk_p_q[1]) : (cur_q.price > bk_p_q[0]));
	assign cxl_free   = lvl_rd.cnt <= CW'(1);
	assign cxl_rescan = cxl_free && bk_v_q[lside_q] && bk_idx_q[lside_q] == li_q;
	assign scan_take  = scan_vld_s1 && lvl_rd.occ && lvl_rd.side == scan_side_q &&
		(!scan_fnd_q || (scan_side_q ? (lvl_rd.price < scan_bp_q) : (lvl_rd.price > scan_bp_q)));
	assign ref_qty = (lvl_rd.tot[TW-1:32] != '0) ? 32'hFFFF_FFFF : lvl_rd.tot[31:0];
	assign emit_now = (st_q == S_OUT) && (!out_valid || out_ready);

	assign q_pop = (st_q == S_IDLE) && q_valid;

	always_comb begin
		ord_we = 1'b0;
		ord_wa = cur_oid;
		ord_wd = ord_rd;
		ord_ra = cur_oid;
		lvl_we = 1'b0;
		lvl_wa = li_q;
		lvl_wd = lvl_rd;
		lvl_ra = li_q;
		case (st_q)
			S_SWEEP: begin
				ord_we = sweep_ord;
				ord_wa = OW'(swp_q);
				ord_wd = '0;
				lvl_we = sweep_lvl;
				lvl_wa = LW'(swp_q);
				lvl_wd = '0;
			end
			S_RD1: begin
				lvl_ra = cur_li;
			end
			S_EX1: begin
				if (cur_q.action == obbo_pkg::ACT_ADD && id_ok_q && add_ok) begin
					ord_we = 1'b1;
					ord_wd = '{live: 1'b1, side: cur_q.side, price: cur_q.price,
						qty: cur_q.quantity};
					lvl_we = 1'b1;
					lvl_wa = cur_li;
					if (add_new) begin
						lvl_wd = '{occ: 1'b1, side: cur_q.side, price: cur_q.price,
							cnt: CW'(1), tot: TW'(cur_q.quantity)};
					end else begin
						lvl_wd.cnt = lvl_rd.cnt + CW'(1);
						lvl_wd.tot = lvl_rd.tot + TW'(cur_q.quantity);
					end
				end
			end
			S_EX2: begin
				lvl_we = 1'b1;
				ord_we = 1'b1;
				if (cur_q.action == obbo_pkg::ACT_MODIFY) begin
					lvl_wd.tot = lvl_rd.tot - TW'(oqty_q) + TW'(cur_q.quantity);
					ord_wd.qty = cur_q.quantity;
					ord_wd.live = 1'b1;
					ord_wd.side = lside_q;
					ord_wd.price = {cur_q.price[31:0]};
				end else begin
					ord_wd = '0;
					if (cxl_free) begin
						lvl_wd = '0;
					end else begin
						lvl_wd.cnt = lvl_rd.cnt - CW'(1);
						lvl_wd.tot = lvl_rd.tot - TW'(oqty_q);
					end
				end
			end
			S_SCAN: begin
				lvl_ra = scan_q;
			end
			S_REF: begin
				lvl_ra = bk_idx_q[cur_q.side];
			end
			default: begin
			end
		endcase
	end

	// modify keeps stored price and side: write back only the quantity
	obbo_pkg::order_t ord_keep_q;

	always_ff @(posedge clk) begin
		if (ord_we) begin
			if (st_q == S_EX2 && cur_q.action == obbo_pkg::ACT_MODIFY) begin
				ord_mem[ord_wa] <= '{live: 1'b1, side: lside_q, price: ord_keep_q.price,
					qty: cur_q.quantity};
			end else begin
				ord_mem[ord_wa] <= ord_wd;
			end
		end
		ord_rd <= ord_mem[ord_ra];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
		lvl_rd <= lvl_mem[lvl_ra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_item;
			refresh_q <= refresh_now;
			id_ok_q   <= id_ok_now;
		end
		if (st_q == S_EX1) begin
			li_q       <= LW'(ord_rd.price);
			lside_q    <= ord_rd.side;
			oqty_q     <= ord_rd.qty;
			ord_keep_q <= ord_rd;
		end
		scan_idx_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_SWEEP;
			swp_q       <= '0;
			emit_q      <= 1'b0;
			scan_q      <= '0;
			scan_vld_s1 <= 1'b0;
			scan_side_q <= 1'b0;
			scan_fnd_q  <= 1'b0;
			scan_bi_q   <= '0;
			scan_bp_q   <= '0;
			bk_v_q      <= '0;
			bk_idx_q    <= '{default: '0};
			bk_p_q      <= '{default: '0};
			bbo_v_q     <= '0;
			bbo_p_q     <= '{default: '0};
			bbo_qty_q   <= '{default: '0};
			out_valid   <= 1'b0;
			is_trade    <= 1'b0;
			echo_side   <= 1'b0;
			echo_price  <= '0;
		end else begin
			if (emit_now) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			scan_vld_s1 <= (st_q == S_SCAN);
			case (st_q)
				S_SWEEP: begin
					swp_q <= swp_q + SW'(1);
					if (swp_q == SW'(obbo_pkg::SWP_N - 1)) begin
						st_q  <= emit_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_item.action)
							obbo_pkg::ACT_TRADE: st_q <= S_OUT;
							obbo_pkg::ACT_CLEAR: begin
								emit_q  <= 1'b1;
								bk_v_q  <= '0;
								bbo_v_q <= '0;
								bbo_p_q   <= '{default: '0};
								bbo_qty_q <= '{default: '0};
								st_q    <= S_SWEEP;
							end
							obbo_pkg::ACT_ADD, obbo_pkg::ACT_MODIFY, obbo_pkg::ACT_CANCEL:
								st_q <= id_ok_now ? S_RD1 : S_REF;
							default: st_q <= S_REF;
						endcase
					end
				end
				S_RD1: st_q <= S_EX1;
				S_EX1: begin
					if (cur_q.action == obbo_pkg::ACT_ADD) begin
						if (add_ok && add_new && add_better) begin
							bk_v_q[cur_q.side]   <= 1'b1;
							bk_idx_q[cur_q.side] <= cur_li;
							bk_p_q[cur_q.side]   <= cur_q.price;
						end
						st_q <= S_REF;
					end else begin
						st_q <= ord_hit ? S_RD2 : S_REF;
					end
				end
				S_RD2: st_q <= S_EX2;
				S_EX2: begin
					if (cur_q.action == obbo_pkg::ACT_CANCEL && cxl_rescan) begin
						scan_side_q <= lside_q;
						scan_fnd_q  <= 1'b0;
						scan_q      <= '0;
						st_q        <= S_SCAN;
					end else begin
						st_q <= S_REF;
					end
				end
				S_SCAN, S_STAIL: begin
					if (scan_take) begin
						scan_fnd_q <= 1'b1;
						scan_bi_q  <= scan_idx_s1;
						scan_bp_q  <= lvl_rd.price;
					end
					if (st_q == S_SCAN) begin
						scan_q      <= scan_q + LW'(1);
						if (scan_q == LW'(obbo_pkg::PRICE_LEVELS - 1)) st_q <= S_STAIL;
					end else begin
						bk_v_q[scan_side_q]   <= scan_take || scan_fnd_q;
						bk_idx_q[scan_side_q] <= scan_take ? scan_idx_s1 : scan_bi_q;
						bk_p_q[scan_side_q]   <= scan_take ? lvl_rd.price : scan_bp_q;
						st_q <= S_REF;
					end
				end
				S_REF: st_q <= refresh_q ? S_REF2 : S_OUT;
				S_REF2: begin
					bbo_v_q[cur_q.side]   <= bk_v_q[cur_q.side];
					bbo_p_q[cur_q.side]   <= bk_v_q[cur_q.side] ? bk_p_q[cur_q.side] : 32'd0;
					bbo_qty_q[cur_q.side] <= bk_v_q[cur_q.side] ? ref_qty : 32'd0;
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (emit_now) begin
						is_trade   <= cur_q.action == obbo_pkg::ACT_TRADE;
						echo_side  <= cur_q.side;
						echo_price <= cur_q.price;
						emit_q     <= 1'b0;
						st_q       <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign bid_valid    = obbo_out_v_q[0];
	assign best_bid     = obbo_out_p_q[0];
	assign best_bid_qty = obbo_out_qty_q[0];
	assign ask_valid    = obbo_out_v_q[1];
	assign best_ask     = obbo_out_p_q[1];
	assign best_ask_qty = obbo_out_qty_q[1];

	always_ff @(posedge clk) begin
		if (emit_now) begin
			obbo_out_v_q   <= bbo_v_q;
			obbo_out_p_q   <= bbo_p_q;
			obbo_out_qty_q <= bbo_qty_q;
		end
	end
endmodule
`default_nettype wire

[rtl/order_book_best_bid_offer.sv]
// Trade items go straight to the output state; add, modify and cancel read and may update the memories;
// a cancel that empties the best level of its side adds a rescan of all price levels. A clear
// runs the sweep over the order and level memories. One item in the back end at a time.
// Reset: asynchronous; afterwards a sweep clears the order and level memories before the
// first item is taken from the queue.
`timescale 1ns / 1ps
`default_nettype none
module order_book_best_bid_offer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  action,
	input  wire logic [11:0] ord_id,
	input  wire logic        side,
	input  wire logic [31:0] price,
	input  wire logic [31:0] quantity,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_trade,
	output logic             echo_side,
	output logic [31:0]      echo_price,
	output logic             bid_valid,
	output logic [31:0]      best_bid,
	output logic [31:0]      best_bid_qty,
	output logic             ask_valid,
	output logic [31:0]      best_ask,
	output logic [31:0]      best_ask_qty
);
	obbo_pkg::item_t in_item, q_item;
	logic q_valid, q_pop;

	assign in_item = '{action: action, ord_id: ord_id, side: side, price: price,
		quantity: quantity};

	obbo_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	obbo_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_trade(is_trade), .echo_side(echo_side), .echo_price(echo_price),
		.bid_valid(bid_valid), .best_bid(best_bid), .best_bid_qty(best_bid_qty),
		.ask_valid(ask_valid), .best_ask(best_ask), .best_ask_qty(best_ask_qty)
	);
endmodule
`default_nettype wire

[tb/order_book_best_bid_offer_tb.sv]
// Self-checking testbench for order_book_best_bid_offer: random and directed market updates,
// a behavioral book model predicts each BBO result, a scoreboard class compares them.
// Depends on rtl/obbo_pkg.sv and rtl/order_book_best_bid_offer.sv.
`timescale 1ns / 1ps
module order_book_best_bid_offer_tb;
	localparam logic [2:0] ACT_OTHER = 3'd5;

	typedef struct packed {
		logic        is_trade;
		logic        echo_side;
		logic [31:0] echo_price;
		logic        bid_valid;
		logic [31:0] best_bid;
		logic [31:0] best_bid_qty;
		logic        ask_valid;
		logic [31:0] best_ask;
		logic [31:0] best_ask_qty;
	} bbo_t;

	int mismatches = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	class book_scoreboard;
		bit          ord_live[obbo_pkg::ORDER_SLOTS];
		bit          ord_side[obbo_pkg::ORDER_SLOTS];
		logic [31:0] ord_price[obbo_pkg::ORDER_SLOTS];
		logic [31:0] ord_qty[obbo_pkg::ORDER_SLOTS];
		bit          lvl_occ[obbo_pkg::PRICE_LEVELS];
		bit          lvl_side[obbo_pkg::PRICE_LEVELS];
		logic [31:0] lvl_price[obbo_pkg::PRICE_LEVELS];
		logic [63:0] lvl_tot[obbo_pkg::PRICE_LEVELS];
		int          lvl_cnt[obbo_pkg::PRICE_LEVELS];
		bit          held_v[2];
		logic [31:0] held_p[2];
		logic [31:0] held_q[2];
		bbo_t        pending[$];

		function void wipe();
			for (int i = 0; i < obbo_pkg::ORDER_SLOTS; i++) ord_live[i] = 0;
			for (int i = 0; i < obbo_pkg::PRICE_LEVELS; i++) begin
				lvl_occ[i] = 0;
				lvl_cnt[i] = 0;
				lvl_tot[i] = 0;
			end
			for (int s = 0; s < 2; s++) begin
				held_v[s] = 0;
				held_p[s] = 0;
				held_q[s] = 0;
			end
		endfunction

		function bit best_level(bit sd, output logic [31:0] bp, output logic [63:0] bq);
			bit found;
			found = 0;
			bp = 0;
			bq = 0;
			for (int i = 0; i < obbo_pkg::PRICE_LEVELS; i++) begin
				if (lvl_occ[i] && lvl_side[i] == sd &&
						(!found || (sd == 0 ? lvl_price[i] > bp : lvl_price[i] < bp))) begin
					found = 1;
					bp = lvl_price[i];
					bq = lvl_tot[i];
				end
			end
			return found;
		endfunction

		function void note_input(obbo_pkg::item_t it);
			logic [31:0] bp;
			logic [63:0] bq;
			bit had, refresh, now;
			int li, id;
			bbo_t r;
			id = it.ord_id;
			if (it.action != obbo_pkg::ACT_TRADE) begin
				had = best_level(it.side, bp, bq);
				refresh = !had || (it.side == 0 ? it.price >= bp : it.price <= bp);
				if (it.action == obbo_pkg::ACT_ADD) begin
					li = it.price % obbo_pkg::PRICE_LEVELS;
					if (!ord_live[id]) begin
						if (!lvl_occ[li]) begin
							lvl_occ[li] = 1;
							lvl_side[li] = it.side;
							lvl_price[li] = it.price;
							lvl_tot[li] = it.quantity;
							lvl_cnt[li] = 1;
							ord_live[id] = 1;
						end else if (lvl_side[li] == it.side && lvl_price[li] == it.price) begin
							lvl_tot[li] += it.quantity;
							lvl_cnt[li]++;
							ord_live[id] = 1;
						end
						if (ord_live[id]) begin
							ord_side[id] = it.side;
							ord_price[id] = it.price;
							ord_qty[id] = it.quantity;
						end
					end
				end else if (it.action == obbo_pkg::ACT_MODIFY && ord_live[id]) begin
					li = ord_price[id] % obbo_pkg::PRICE_LEVELS;
					lvl_tot[li] = lvl_tot[li] - ord_qty[id] + it.quantity;
					ord_qty[id] = it.quantity;
				end else if (it.action == obbo_pkg::ACT_CANCEL && ord_live[id]) begin
					li = ord_price[id] % obbo_pkg::PRICE_LEVELS;
					lvl_tot[li] -= ord_qty[id];
					if (lvl_cnt[li] <= 1) begin
						lvl_occ[li] = 0;
						lvl_cnt[li] = 0;
						lvl_tot[li] = 0;
					end else lvl_cnt[li]--;
					ord_live[id] = 0;
				end else if (it.action == obbo_pkg::ACT_CLEAR) begin
					wipe();
				end
				if (it.action != obbo_pkg::ACT_CLEAR && refresh) begin
					now = best_level(it.side, bp, bq);
					held_v[it.side] = now;
					held_p[it.side] = now ? bp : 0;
					held_q[it.side] = !now ? 0 : (bq > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : bq[31:0]);
				end
			end
			r.is_trade = it.action == obbo_pkg::ACT_TRADE;
			r.echo_side = it.side;
			r.echo_price = it.price;
			r.bid_valid = held_v[0];
			r.best_bid = held_p[0];
			r.best_bid_qty = held_q[0];
			r.ask_valid = held_v[1];
			r.best_ask = held_p[1];
			r.best_ask_qty = held_q[1];
			pending.push_back(r);
		endfunction

		task check_result(bbo_t g);
			bbo_t w;
			if (pending.size() == 0) begin
				report("unexpected result", g.echo_price, 0);
				return;
			end
			w = pending.pop_front();
			if (g.is_trade !== w.is_trade) report("is_trade", g.is_trade, w.is_trade);
			if (g.echo_side !== w.echo_side) report("echo_side", g.echo_side, w.echo_side);
			if (g.echo_price !== w.echo_price) report("echo_price", g.echo_price, w.echo_price);
			if (g.bid_valid !== w.bid_valid) report("bid_valid", g.bid_valid, w.bid_valid);
			if (g.best_bid !== w.best_bid) report("best_bid", g.best_bid, w.best_bid);
			if (g.best_bid_qty !== w.best_bid_qty)
				report("best_bid_qty", g.best_bid_qty, w.best_bid_qty);
			if (g.ask_valid !== w.ask_valid) report("ask_valid", g.ask_valid, w.ask_valid);
			if (g.best_ask !== w.best_ask) report("best_ask", g.best_ask, w.best_ask);
			if (g.best_ask_qty !== w.best_ask_qty)
				report("best_ask_qty", g.best_ask_qty, w.best_ask_qty);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  action = 0;
	logic [11:0] ord_id = 0;
	logic        side = 0;
	logic [31:0] price = 0;
	logic [31:0] quantity = 0;
	logic        out_valid;
	logic        out_ready = 0;
	bbo_t        res;

	int send_idle = 38;
	int recv_idle = 78;
	book_scoreboard sb;

	order_book_best_bid_offer i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .ord_id(ord_id), .side(side), .price(price), .quantity(quantity),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_trade(res.is_trade), .echo_side(res.echo_side), .echo_price(res.echo_price),
		.bid_valid(res.bid_valid), .best_bid(res.best_bid), .best_bid_qty(res.best_bid_qty),
		.ask_valid(res.ask_valid), .best_ask(res.best_ask), .best_ask_qty(res.best_ask_qty)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(res);
		out_ready <= $urandom_range(99) >= recv_idle;
	end

	task automatic send(logic [2:0] a, logic [11:0] id, logic sd, logic [31:0] p, logic [31:0] q);
		bit idle;
		idle = $urandom_range(99) < send_idle;
		if (idle) in_valid <= 0;
		while (idle) begin
			@(posedge clk);
			idle = $urandom_range(99) < send_idle;
		end
		in_valid <= 1;
		action <= a;
		ord_id <= id;
		side <= sd;
		price <= p;
		quantity <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input('{a, id, sd, p, q});
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (3 * obbo_pkg::PRICE_LEVELS) @(posedge clk);
	endtask

	// Prices cluster around a small set of bases so levels collide and BBOs move.
	function automatic logic [31:0] pick_price();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(40);
			2: return $urandom_range(40);
			default: return 32'h8000_0000 + $urandom_range(60);
		endcase
	endfunction

	task automatic random_item(int id_span);
		int r;
		logic [31:0] q;
		r = $urandom_range(99);
		q = ($urandom_range(9) == 0) ? $urandom() | 32'hF000_0000 : $urandom_range(1000);
		if (r < 45)
			send(obbo_pkg::ACT_ADD, 12'($urandom_range(id_span)), 1'($urandom_range(1)),
				pick_price(), q);
		else if (r < 60)
			send(obbo_pkg::ACT_MODIFY, 12'($urandom_range(id_span)), 1'($urandom_range(1)),
				pick_price(), q);
		else if (r < 85)
			send(obbo_pkg::ACT_CANCEL, 12'($urandom_range(id_span)), 1'($urandom_range(1)),
				pick_price(), q);
		else if (r < 92)
			send(obbo_pkg::ACT_TRADE, 12'($urandom()), 1'($urandom_range(1)), $urandom(),
				$urandom());
		else if (r < 99)
			send(3'(ACT_OTHER + $urandom_range(2)), 12'($urandom()), 1'($urandom_range(1)),
				pick_price(), $urandom());
		else
			send(obbo_pkg::ACT_CLEAR, 12'($urandom()), 1'($urandom_range(1)), $urandom(),
				$urandom());
	endtask

	initial begin
		sb = new();
		sb.wipe();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(ACT_OTHER, 0, 0, 0, 0);
		send(obbo_pkg::ACT_ADD, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(obbo_pkg::ACT_ADD, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(obbo_pkg::ACT_ADD, 4095, 1, 0, 0);
		send(obbo_pkg::ACT_ADD, 4095, 1, 5, 7);
		send(obbo_pkg::ACT_ADD, 2, 1, 1024, 3);
		send(obbo_pkg::ACT_ADD, 3, 0, 32'h3FF, 9);
		send(obbo_pkg::ACT_MODIFY, 1, 1, 32'h1234, 5);
		send(obbo_pkg::ACT_MODIFY, 77, 0, 32'hFFFF_FFFF, 5);
		send(obbo_pkg::ACT_CANCEL, 88, 1, 0, 0);
		send(obbo_pkg::ACT_TRADE, 12'hFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(3'd6, 12'hAAA, 0, 32'h5555_5555, 32'hAAAA_AAAA);
		send(3'd7, 12'h555, 1, 32'hAAAA_AAAA, 32'h5555_5555);
		send(obbo_pkg::ACT_CANCEL, 0, 0, 0, 0);
		send(obbo_pkg::ACT_CANCEL, 1, 0, 0, 0);
		send(obbo_pkg::ACT_CANCEL, 4095, 1, 0, 0);
		send(obbo_pkg::ACT_ADD, 5, 1, 2048, 1);
		send(obbo_pkg::ACT_CANCEL, 2, 1, 0, 0);
		send(obbo_pkg::ACT_CLEAR, 0, 0, 0, 0);
		send(obbo_pkg::ACT_ADD, 6, 0, 100, 4);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 38 : ph == 1 ? 78 : 0;
			recv_idle = ph == 0 ? 78 : ph == 1 ? 38 : 0;
			for (int n = 0; n < 540; n++) begin
				random_item(n % 5 == 0 ? 4095 : 63);
				if (n == 270) drain();
			end
		end
		drain();
		if (mismatches == 0 && sb.pending.size() == 0)
			$display("** order_book_best_bid_offer: PASSED **");
		else begin
			if (sb.pending.size() != 0) report("results missing", sb.pending.size(), 0);
			$display("** order_book_best_bid_offer: FAILED **");
		end
		$finish;
	end

	initial begin
		#400ms;
		$display("** order_book_best_bid_offer: FAILED **");
		$finish;
	end
endmodule

[files.f]
rtl/obbo_pkg.sv
rtl/obbo_front.sv
rtl/obbo_back.sv
rtl/order_book_best_bid_offer.sv
tb/order_book_best_bid_offer_tb.sv
